/* rtl/irpd_pkg.sv */
`default_nettype none

package irpd_pkg;

   localparam int unsigned EdgeTimeWidth = 32;
   localparam int unsigned AddressWidth  = 24;
   localparam int unsigned CommandWidth  = 16;
   localparam int unsigned ExtraWidth    = 2;
   localparam int unsigned CountWidth    = 6;
   localparam int unsigned StoreDepth    = 5;
   localparam int unsigned RspDataWidth  = 48;

   localparam logic [EdgeTimeWidth-1:0] GAP_MIN        = 32'd800;
   localparam logic [EdgeTimeWidth-1:0] HDR_A_LO       = 32'd8850;
   localparam logic [EdgeTimeWidth-1:0] HDR_A_HI       = 32'd9150;
   localparam logic [EdgeTimeWidth-1:0] HDR_B_LO       = 32'd13300;
   localparam logic [EdgeTimeWidth-1:0] HDR_B_HI       = 32'd13700;
   localparam logic [EdgeTimeWidth-1:0] ZERO_LO        = 32'd1000;
   localparam logic [EdgeTimeWidth-1:0] ZERO_HI        = 32'd1500;
   localparam logic [EdgeTimeWidth-1:0] ONE_LO         = 32'd2000;
   localparam logic [EdgeTimeWidth-1:0] ONE_HI         = 32'd2500;
   localparam logic [EdgeTimeWidth-1:0] LOCK_A_GAP     = 32'd46600;
   localparam logic [EdgeTimeWidth-1:0] LOCK_B_GAP     = 32'd22000;
   localparam logic [CountWidth-1:0]    FRAME_A_BITS   = 6'd32;
   localparam logic [CountWidth-1:0]    FRAME_B_BITS   = 6'd42;

   localparam logic VARIANT_A = 1'b0;
   localparam logic VARIANT_B = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DATA_A = 3'd1,
      PH_DATA_B = 3'd2,
      PH_LOCK_A = 3'd3,
      PH_LOCK_B = 3'd4
   } phase_type;

   typedef struct packed {
      logic                    valid;
      logic                    frame_variant;
      logic [AddressWidth-1:0] device_address;
      logic [CommandWidth-1:0] key_command;
      logic [ExtraWidth-1:0]   extra_bits;
   } result_type;

endpackage

`default_nettype wire

/* rtl/irpd_decode.sv */
`default_nettype none

module irpd_decode (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   step,
   input  wire  [irpd_pkg::EdgeTimeWidth-1:0]    edge_time,
   output irpd_pkg::result_type                  result
);
   import irpd_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic [EdgeTimeWidth-1:0]  prev_ff, prev_in;
   logic [7:0]                partial_ff, partial_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic [7:0]                store_ff [StoreDepth];
   logic [7:0]                store_in [StoreDepth];

   logic [EdgeTimeWidth-1:0]  gap;
   logic                      is_zero, is_one;
   logic [CountWidth-1:0]     count_inc;
   logic [7:0]                partial_set;
   logic [2:0]                byte_idx;

   assign gap         = edge_time - prev_ff;
   assign is_zero     = (gap > ZERO_LO) && (gap < ZERO_HI);
   assign is_one      = (gap > ONE_LO) && (gap < ONE_HI);
   assign count_inc   = count_ff + 1'b1;
   assign partial_set = partial_ff | ({7'd0, is_one} << count_ff[2:0]);
   assign byte_idx    = count_inc[CountWidth-1:3] - 3'd1;

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      partial_in = partial_ff;
      count_in   = count_ff;
      store_in   = store_ff;
      result     = '0;
      if (step && gap >= GAP_MIN) begin
         case (phase_ff)
            PH_IDLE: begin
               partial_in = '0;
               count_in   = '0;
               for (int i = 0; i < StoreDepth; i++) begin
                  store_in[i] = '0;
               end
               if (gap >= HDR_B_LO && gap <= HDR_B_HI) begin
                  phase_in = PH_DATA_B;
               end else if (gap >= HDR_A_LO && gap <= HDR_A_HI) begin
                  phase_in = PH_DATA_A;
               end
               prev_in = edge_time;
            end
            PH_LOCK_A: begin
               if (gap > LOCK_A_GAP) begin
                  phase_in = PH_IDLE;
                  prev_in  = edge_time;
               end
            end
            PH_LOCK_B: begin
               if (gap > LOCK_B_GAP) begin
                  phase_in = PH_IDLE;
                  prev_in  = edge_time;
               end
            end
            PH_DATA_A, PH_DATA_B: begin
               prev_in = edge_time;
               if (is_zero || is_one) begin
                  count_in = count_inc;
                  if (count_inc[2:0] == 3'd0 && count_inc != '0) begin
                     if (byte_idx < 3'(StoreDepth)) begin
                        store_in[byte_idx] = partial_set;
                     end
                     partial_in = '0;
                  end else begin
                     partial_in = partial_set;
                  end
                  if (phase_ff == PH_DATA_A && count_inc == FRAME_A_BITS) begin
                     result.valid          = 1'b1;
                     result.frame_variant  = VARIANT_A;
                     result.device_address = {8'd0, store_in[0], store_in[1]};
                     result.key_command    = {store_in[2], store_in[3]};
                     result.extra_bits     = '0;
                     phase_in              = PH_LOCK_A;
                  end else if (phase_ff == PH_DATA_B && count_inc == FRAME_B_BITS) begin
                     result.valid          = 1'b1;
                     result.frame_variant  = VARIANT_B;
                     result.device_address = {store_in[2], store_in[1], store_in[0]};
                     result.key_command    = {store_in[4], store_in[3]};
                     result.extra_bits     = partial_set[1:0];
                     phase_in              = PH_LOCK_B;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               prev_in  = edge_time;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         prev_ff    <= '0;
         partial_ff <= '0;
         count_ff   <= '0;
         for (int i = 0; i < StoreDepth; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff   <= phase_in;
         prev_ff    <= prev_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
         store_ff   <= store_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ir_pulse_distance_frame_decoder.sv */
// An accepted edge word passes the input register, then the result register, to rsp_.
// Throughput: one edge word per cycle while rsp_ is not stalled; the input register and
// the result register let a new word in while a finished frame waits on rsp_tready.
// Reset (synchronous, active high): decoder idle, previous edge time, bit
// count and stored bytes cleared, both pipeline registers empty.
`default_nettype none

module ir_pulse_distance_frame_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] edge_time
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] device_address, [39:24] key_command,
                                    // [41:40] extra_bits, [47:42] zero
   output logic [0:0]  rsp_tuser    // [0] frame_variant
);
   import irpd_pkg::*;

   logic                     in_valid_ff, in_valid_in;
   logic [EdgeTimeWidth-1:0] in_time_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0]  rsp_data_ff;
   logic                     rsp_variant_ff;
   logic                     advance;
   result_type               result;

   assign advance     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? result.valid : rsp_valid_ff;

   irpd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (in_valid_ff && advance),
      .edge_time (in_time_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_time_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         rsp_data_ff    <= {6'd0, result.extra_bits, result.key_command,
                            result.device_address};
         rsp_variant_ff <= result.frame_variant;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_variant_ff;

endmodule

`default_nettype wire

/* rtl/irpd_checker.sv */
`default_nettype none

module irpd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire [0:0]  rsp_tuser
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:42] == 6'd0)
      else $error("rsp padding not zero");

   // short frame: no extra bits, 16-bit address
   a_variant_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == 1'b0 |-> rsp_tdata[41:40] == 2'd0 &&
      rsp_tdata[23:16] == 8'd0)
      else $error("short frame carries long-frame fields");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with output free");

endmodule

bind ir_pulse_distance_frame_decoder irpd_checker u_irpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import irpd_pkg::*;

   localparam int unsigned EDGE_TARGET    = 1100;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_LIMIT    = 1000;
   localparam int unsigned DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic                    variant;
      logic [AddressWidth-1:0] address;
      logic [CommandWidth-1:0] command;
      logic [ExtraWidth-1:0]   extra;
   } decoded_frame_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] edge_time
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [23:0] device_address, [39:24] key_command,
                                   // [41:40] extra_bits, [47:42] zero
   logic [0:0]  rsp_tuser;         // [0] frame_variant

   // decoder shadow state
   phase_type   dec_phase  = PH_IDLE;
   logic [31:0] last_edge  = '0;
   logic [7:0]  shift_byte = '0;
   logic [5:0]  bits_seen  = '0;
   logic [7:0]  rx_bytes [StoreDepth] = '{default: '0};

   decoded_frame_type pending_frames [$];
   int unsigned    sent_edges      = 0;
   int unsigned    mismatches      = 0;
   int unsigned    quiet_cycles    = 0;
   int unsigned    rsp_hold        = 0;
   bit             no_gaps         = 1'b0;

   ir_pulse_distance_frame_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // advance the shadow decoder by one edge
   function automatic void decode_edge(input logic [31:0] stamp);
      logic [31:0]       gap;
      decoded_frame_type frame;
      gap = stamp - last_edge;
      if (gap < GAP_MIN) return;
      case (dec_phase)
         PH_IDLE: begin
            shift_byte = '0;
            bits_seen  = '0;
            foreach (rx_bytes[i]) rx_bytes[i] = '0;
            if (gap >= HDR_B_LO && gap <= HDR_B_HI) dec_phase = PH_DATA_B;
            else if (gap >= HDR_A_LO && gap <= HDR_A_HI) dec_phase = PH_DATA_A;
            last_edge = stamp;
         end
         PH_LOCK_A, PH_LOCK_B: begin
            if (gap <= ((dec_phase == PH_LOCK_A) ? LOCK_A_GAP : LOCK_B_GAP)) return;
            dec_phase = PH_IDLE;
            last_edge = stamp;
         end
         PH_DATA_A, PH_DATA_B: begin
            last_edge = stamp;
            if (gap > ZERO_LO && gap < ZERO_HI) begin
               bits_seen = bits_seen + 6'd1;
            end else if (gap > ONE_LO && gap < ONE_HI) begin
               shift_byte[bits_seen[2:0]] = 1'b1;
               bits_seen = bits_seen + 6'd1;
            end else begin
               dec_phase = PH_IDLE;
               return;
            end
            if (bits_seen[2:0] == 3'd0 && bits_seen != 6'd0) begin
               if (bits_seen[5:3] <= 3'(StoreDepth)) rx_bytes[bits_seen[5:3] - 3'd1] = shift_byte;
               shift_byte = '0;
            end
            if (dec_phase == PH_DATA_A && bits_seen == FRAME_A_BITS) begin
               frame.variant = VARIANT_A;
               frame.address = {8'h00, rx_bytes[0], rx_bytes[1]};
               frame.command = {rx_bytes[2], rx_bytes[3]};
               frame.extra   = '0;
               pending_frames.push_back(frame);
               dec_phase = PH_LOCK_A;
            end else if (dec_phase == PH_DATA_B && bits_seen == FRAME_B_BITS) begin
               frame.variant = VARIANT_B;
               frame.address = {rx_bytes[2], rx_bytes[1], rx_bytes[0]};
               frame.command = {rx_bytes[4], rx_bytes[3]};
               frame.extra   = shift_byte[1:0];
               pending_frames.push_back(frame);
               dec_phase = PH_LOCK_B;
            end
         end
         default: begin
            dec_phase = PH_IDLE;
            last_edge = stamp;
         end
      endcase
   endfunction

   task automatic send_edge(input logic [31:0] stamp);
      int unsigned idle_cycles;
      idle_cycles = no_gaps ? 0 : $urandom_range(0, 15);
      if (idle_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_edge(stamp);
      sent_edges++;
   endtask

   task automatic send_gap(input logic [31:0] gap);
      send_edge(last_edge + gap);
   endtask

   function automatic logic [31:0] header_gap(input logic variant);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = (variant == VARIANT_B) ? HDR_B_LO : HDR_A_LO;
      hi = (variant == VARIANT_B) ? HDR_B_HI : HDR_A_HI;
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic logic [31:0] bit_gap(input logic value);
      case ($urandom_range(0, 5))
         0: return value ? ONE_LO + 1 : ZERO_LO + 1;
         1: return value ? ONE_HI - 1 : ZERO_HI - 1;
         default: return value ? $urandom_range(ONE_LO + 1, ONE_HI - 1)
                               : $urandom_range(ZERO_LO + 1, ZERO_HI - 1);
      endcase
   endfunction

   function automatic logic [31:0] bad_gap();
      case ($urandom_range(0, 7))
         0: return GAP_MIN;
         1: return ZERO_LO;
         2: return ZERO_HI;
         3: return ONE_LO;
         4: return ONE_HI;
         5: return $urandom_range(ZERO_HI, ONE_LO);
         6: return $urandom_range(ONE_HI, HDR_B_HI + 1000);
         default: return $urandom_range(GAP_MIN, ZERO_LO);
      endcase
   endfunction

   // header, then bits LSB first; break_at replaces that bit with a bad gap
   task automatic send_frame(input logic variant, input logic [31:0] hdr,
                             input logic [41:0] payload, input int break_at);
      int nbits;
      nbits = int'((variant == VARIANT_B) ? FRAME_B_BITS : FRAME_A_BITS);
      send_gap(hdr);
      for (int i = 0; i < nbits; i++) begin
         if ($urandom_range(0, 15) == 0) send_gap($urandom_range(0, GAP_MIN - 1));
         if (i == break_at) begin
            send_gap(bad_gap());
            return;
         end
         send_gap(bit_gap(payload[i]));
      end
   endtask

   // up to two ignored edges inside the lock window, then one past it
   task automatic release_lock();
      logic [31:0] lock_gap;
      if (dec_phase != PH_LOCK_A && dec_phase != PH_LOCK_B) return;
      lock_gap = (dec_phase == PH_LOCK_A) ? LOCK_A_GAP : LOCK_B_GAP;
      repeat ($urandom_range(0, 2)) send_gap($urandom_range(0, lock_gap));
      send_gap(lock_gap + $urandom_range(1, 4000));
   endtask

   task automatic test_variant_a_lock();
      send_gap(GAP_MIN - 1);
      send_frame(VARIANT_A, HDR_A_HI, '1, -1);
      send_gap(LOCK_A_GAP);
      send_gap(LOCK_A_GAP + 1);
   endtask

   task automatic test_variant_b_lock();
      send_frame(VARIANT_B, HDR_B_LO, 42'h2_A5_C3_96_0F_81, -1);
      send_gap(LOCK_B_GAP);
      send_gap(LOCK_B_GAP + 1);
   endtask

   task automatic test_gap_limits();
      logic [31:0] limits [5] = '{ZERO_LO, ZERO_HI, ONE_LO, ONE_HI, GAP_MIN};
      send_gap(HDR_A_LO - 1);
      send_gap(HDR_A_HI + 1);
      send_gap(HDR_B_LO - 1);
      send_gap(HDR_B_HI + 1);
      foreach (limits[i]) begin
         send_gap((i % 2) ? HDR_B_HI : HDR_A_LO);
         send_gap(bit_gap(1'b1));
         send_gap(limits[i]);
      end
   endtask

   task automatic test_wraparound();
      send_edge(32'hFFFF_E000);
      send_frame(VARIANT_A, header_gap(VARIANT_A), '0, -1);
      release_lock();
      send_edge(last_edge - 1);   // gap of all ones
      send_edge(last_edge);       // zero gap
      send_frame(VARIANT_B, header_gap(VARIANT_B), '0, -1);
      release_lock();
   endtask

   task automatic test_back_pressure();
      no_gaps  = 1'b1;
      rsp_hold = HOLD_CYCLES;
      repeat (4) begin
         release_lock();
         send_frame(VARIANT_A, header_gap(VARIANT_A), 42'({$urandom(), $urandom()}), -1);
      end
      release_lock();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_frames();
      logic variant;
      while (sent_edges < EDGE_TARGET) begin
         if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
         release_lock();
         variant = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: send_edge($urandom());
            1: send_gap($urandom_range(GAP_MIN, 60000));
            default: send_frame(variant, header_gap(variant), 42'({$urandom(), $urandom()}),
                                ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 41)) : -1);
         endcase
      end
      no_gaps = 1'b0;
   endtask

   initial begin : frame_sink
      int unsigned       stall;
      decoded_frame_type want;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (pending_frames.size() == 0) begin
            $error("frame word with none expected: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_tuser[0] !== want.variant) begin
               $error("frame_variant: expected %0d, got %0d", want.variant, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tdata[23:0] !== want.address) begin
               $error("device_address: expected %h, got %h", want.address, rsp_tdata[23:0]);
               mismatches++;
            end
            if (rsp_tdata[39:24] !== want.command) begin
               $error("key_command: expected %h, got %h", want.command, rsp_tdata[39:24]);
               mismatches++;
            end
            if (rsp_tdata[41:40] !== want.extra) begin
               $error("extra_bits: expected %0d, got %0d", want.extra, rsp_tdata[41:40]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : test_sequence
      int unsigned waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_variant_a_lock();
      test_variant_b_lock();
      test_gap_limits();
      test_wraparound();
      test_back_pressure();
      test_random_frames();
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $error("%0d frame words never arrived", pending_frames.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
